### hdl/kabf_pkg.sv
// Shared types, constants and fixed-point helpers for the tilt filter.
`default_nettype none
package kabf_pkg;
  localparam int FRAC_BITS = 24;
  localparam logic [23:0] DT_RESET = 24'd167772;
  localparam logic [30:0] QA_RESET = 31'd16777;
  localparam logic [30:0] QB_RESET = 31'd50332;
  localparam logic [30:0] MN_RESET = 31'd503316;
  localparam logic signed [24:0] NINETY_Q16 = 25'sd5898240;

  localparam logic [1:0] REG_DT = 2'd0;
  localparam logic [1:0] REG_QA = 2'd1;
  localparam logic [1:0] REG_QB = 2'd2;
  localparam logic [1:0] REG_MN = 2'd3;

  // operand selectors for the shared multiply-accumulate
  localparam logic [4:0] OP_ANG   = 5'd0;
  localparam logic [4:0] OP_DTP11 = 5'd1;
  localparam logic [4:0] OP_P00   = 5'd2;
  localparam logic [4:0] OP_P01   = 5'd3;
  localparam logic [4:0] OP_P10   = 5'd4;
  localparam logic [4:0] OP_P11   = 5'd5;
  localparam logic [4:0] OP_DIVK0 = 5'd6;
  localparam logic [4:0] OP_DIVK1 = 5'd7;
  localparam logic [4:0] OP_INNOV = 5'd8;
  localparam logic [4:0] OP_ANGU  = 5'd9;
  localparam logic [4:0] OP_BIAS  = 5'd10;
  localparam logic [4:0] OP_CAA   = 5'd11;
  localparam logic [4:0] OP_CAB   = 5'd12;
  localparam logic [4:0] OP_CBA   = 5'd13;
  localparam logic [4:0] OP_CBB   = 5'd14;
  localparam logic [4:0] OP_NONE  = 5'd15;

  typedef struct packed {
    logic       load;
    logic       axis;
    logic [4:0] op;
    logic       start;
  } kabf_cmd_t;

  typedef struct packed {
    logic busy;
  } kabf_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = 32'h7FFFFFFF;
    else if (v < -66'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

  // shift right by 24, rounding half away from zero
  function automatic logic signed [65:0] rnd24(input logic signed [65:0] v);
    logic [65:0] m;
    logic [65:0] r;
    m = v[65] ? (66'd0 - v) : v;
    r = (m + 66'd8388608) >> FRAC_BITS;
    rnd24 = v[65] ? -$signed(r) : $signed(r);
  endfunction
endpackage
`default_nettype wire

### hdl/kabf_div.sv
// Restoring divider, one quotient bit per cycle, signed, truncating.
`default_nettype none
module kabf_div
  import kabf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [32:0] den,
  output logic                    busy,
  output logic signed [31:0]      quo
);
  localparam int NB = 56;
  logic [NB-1:0] n_r, n_nxt;
  logic [32:0] d_r;
  logic [33:0] rem_r, rem_nxt;
  logic [5:0] cnt_r;
  logic neg_r, zero_r;
  logic [33:0] trial;
  logic signed [65:0] q_s;

  always_comb begin
    trial = {rem_r[32:0], n_r[NB-1]};
    if (trial >= {1'b0, d_r}) rem_nxt = trial - {1'b0, d_r};
    else rem_nxt = trial;
    n_nxt = {n_r[NB-2:0], trial >= {1'b0, d_r}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 6'(NB);
    end else if (cnt_r != 0) begin
      cnt_r <= cnt_r - 6'd1;
    end
    if (start) begin
      n_r    <= {(num[31] ? (32'd0 - num) : num), 24'd0};
      d_r    <= den;
      rem_r  <= '0;
      neg_r  <= num[31];
      zero_r <= (den <= 0);
    end else if (cnt_r != 0) begin
      n_r   <= n_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    q_s = {10'd0, n_r};
    if (neg_r) q_s = -q_s;
    quo = zero_r ? 32'sd0 : sat32(q_s);
  end
  assign busy = (cnt_r != 0);
endmodule
`default_nettype wire

### hdl/kabf_dp.sv
// Datapath: state registers, one shared multiplier, divider for gains.
`default_nettype none
module kabf_dp
  import kabf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire kabf_cmd_t          cmd,
  output kabf_sts_t               sts,
  input  wire logic [23:0]        dt,
  input  wire logic [30:0]        qa,
  input  wire logic [30:0]        qb,
  input  wire logic [30:0]        mn,
  input  wire logic signed [24:0] roll_in,
  input  wire logic signed [23:0] pitch_in,
  input  wire logic signed [27:0] rrate_in,
  input  wire logic signed [27:0] prate_in,
  output logic signed [31:0]      roll_o,
  output logic signed [31:0]      pitch_o
);
  logic signed [31:0] ang_r [2];
  logic signed [31:0] bias_r [2];
  logic signed [31:0] paa_r [2];
  logic signed [31:0] pab_r [2];
  logic signed [31:0] pba_r [2];
  logic signed [31:0] pbb_r [2];
  logic signed [31:0] dtp_r, k0_r, k1_r, y_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [32:0] ma;
  logic signed [34:0] mb;
  logic signed [65:0] prod, rp;
  logic signed [31:0] meas, rate;
  logic div_start, div_busy;
  logic signed [31:0] div_num, quo;
  logic signed [32:0] sden;
  logic a;

  assign a = cmd.axis;
  assign meas = a ? 32'(pitch_in) : 32'(roll_in);
  always_comb begin
    if (a) begin
      rate = 32'(prate_in);
      if (roll_in > NINETY_Q16 || roll_in < -NINETY_Q16) rate = -rate;
    end else begin
      rate = 32'(rrate_in);
    end
  end
  assign sden = 33'(p00_r) + 33'({1'b0, mn});

  always_comb begin
    ma = 33'({9'd0, dt});
    mb = '0;
    unique case (cmd.op)
      OP_ANG:   mb = 35'(rate) - 35'(bias_r[a]);
      OP_DTP11: mb = 35'(pbb_r[a]);
      // inner term spans four 32-bit values, hence the wider operand
      OP_P00:   mb = 35'(dtp_r) - 35'(pab_r[a]) - 35'(pba_r[a])
                     + 35'($signed({1'b0, qa}));
      OP_P11:   mb = 35'($signed({1'b0, qb}));
      OP_ANGU:  begin ma = 33'(k0_r); mb = 35'(y_r); end
      OP_BIAS:  begin ma = 33'(k1_r); mb = 35'(y_r); end
      OP_CAA:   begin ma = 33'(k0_r); mb = 35'(p00_r); end
      OP_CAB:   begin ma = 33'(k0_r); mb = 35'(p01_r); end
      OP_CBA:   begin ma = 33'(k1_r); mb = 35'(p00_r); end
      OP_CBB:   begin ma = 33'(k1_r); mb = 35'(p01_r); end
      default:  mb = '0;
    endcase
    prod = 66'(ma) * 66'(mb);
    rp = rnd24(prod);
  end

  assign div_start = cmd.start && (cmd.op == OP_DIVK0 || cmd.op == OP_DIVK1);
  assign div_num = (cmd.op == OP_DIVK1) ? p10_r : p00_r;
  kabf_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
                  .den(sden), .busy(div_busy), .quo(quo));
  assign sts.busy = div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        ang_r[i] <= '0; bias_r[i] <= '0; paa_r[i] <= '0;
        pab_r[i] <= '0; pba_r[i] <= '0; pbb_r[i] <= '0;
      end
    end else if (cmd.load) begin
      for (int i = 0; i < 2; i++) begin
        bias_r[i] <= '0; paa_r[i] <= '0; pab_r[i] <= '0;
        pba_r[i] <= '0; pbb_r[i] <= '0;
      end
      ang_r[0] <= 32'(roll_in);
      ang_r[1] <= 32'(pitch_in);
    end else if (cmd.start) begin
      unique case (cmd.op)
        OP_ANG: ang_r[a] <= sat32(66'(ang_r[a]) + rp);
        OP_DTP11: begin
          dtp_r <= sat32(rp);
          p00_r <= paa_r[a];
        end
        OP_P00: p00_r <= sat32(66'(paa_r[a]) + rp);
        OP_P01: p01_r <= sat32(66'(pab_r[a]) - 66'(dtp_r));
        OP_P10: p10_r <= sat32(66'(pba_r[a]) - 66'(dtp_r));
        OP_P11: p11_r <= sat32(66'(pbb_r[a]) + rp);
        OP_DIVK0: ;
        OP_DIVK1: k0_r <= quo;
        OP_INNOV: begin
          k1_r <= quo;
          y_r  <= sat32(66'(meas) - 66'(ang_r[a]));
        end
        OP_ANGU: ang_r[a] <= sat32(66'(ang_r[a]) + rp);
        OP_BIAS: bias_r[a] <= sat32(66'(bias_r[a]) + rp);
        OP_CAA: paa_r[a] <= sat32(66'(p00_r) - rp);
        OP_CAB: pab_r[a] <= sat32(66'(p01_r) - rp);
        OP_CBA: pba_r[a] <= sat32(66'(p10_r) - rp);
        OP_CBB: pbb_r[a] <= sat32(66'(p11_r) - rp);
        default: ;
      endcase
    end
  end
  assign roll_o = ang_r[0];
  assign pitch_o = ang_r[1];
endmodule
`default_nettype wire

### hdl/kabf_ctrl.sv
// Sequencer: walks each axis through predict, gain division and update.
`default_nettype none
module kabf_ctrl
  import kabf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_go,
  output logic           in_rdy,
  output kabf_cmd_t      cmd,
  input  wire kabf_sts_t sts,
  output logic           done
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  logic [1:0] st_r, st_nxt;
  logic [4:0] op_r, op_nxt;
  logic ax_r, ax_nxt, started_r, started_nxt;

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; ax_nxt = ax_r; started_nxt = started_r;
    cmd = '{load: 1'b0, axis: ax_r, op: op_r, start: 1'b0};
    done = 1'b0;
    in_rdy = (st_r == S_IDLE);
    unique case (st_r)
      S_IDLE: if (in_go) begin
        if (!started_r) begin
          cmd.load = 1'b1; started_nxt = 1'b1;
        end else begin
          st_nxt = S_RUN; op_nxt = OP_ANG; ax_nxt = 1'b0;
        end
      end
      S_RUN: begin
        cmd.start = 1'b1;
        // gains need the divider to settle before capture
        if (op_r == OP_DIVK0 || op_r == OP_DIVK1) st_nxt = S_WAIT;
        if (op_r == OP_CBB) begin
          if (ax_r) begin
            st_nxt = S_IDLE; done = 1'b1;
          end else begin
            ax_nxt = 1'b1; op_nxt = OP_ANG;
          end
        end else begin
          op_nxt = op_r + 5'd1;
        end
      end
      S_WAIT: begin
        if (!sts.busy) st_nxt = S_RUN;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; op_r <= OP_NONE; ax_r <= 1'b0; started_r <= 1'b0;
    end else begin
      st_r <= st_nxt; op_r <= op_nxt; ax_r <= ax_nxt; started_r <= started_nxt;
    end
  end
endmodule
`default_nettype wire

### hdl/kalman_angle_bias_filter_top.sv
// Top level of the two-axis tilt Kalman filter.
// Each item runs roll then pitch through one shared multiplier and a
// radix-2 divider; each axis takes 15 sequencer steps plus two gain
// divisions. The result is captured into the output register once the
// last update has landed and is offered from there. The first item after
// reset only seeds the estimates, gives no result and frees the input on
// the next cycle. The result register holds until taken; the next item
// is accepted only once the sequencer is idle and the result slot is free.
`default_nettype none
module kalman_angle_bias_filter_top
  import kabf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // roll_meas[24:0], pitch_meas[48:25], roll_rate[76:49], pitch_rate[104:77]
  input  wire logic [111:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // roll_est[31:0], pitch_est[63:32]
  output logic [63:0]      out_tdata
);
  logic [23:0] dt_r;
  logic [30:0] qa_r, qb_r, mn_r;
  logic signed [24:0] roll_r;
  logic signed [23:0] pitch_r;
  logic signed [27:0] rr_r, pr_r;
  logic ovalid_r;
  logic [63:0] odata_r;
  logic rdy, done, go;
  kabf_cmd_t cmd;
  kabf_sts_t sts;
  logic signed [31:0] ro, po;
  logic done_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DT_RESET; qa_r <= QA_RESET; qb_r <= QB_RESET; mn_r <= MN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DT: dt_r <= cfg_wdata[23:0];
        REG_QA: qa_r <= cfg_wdata;
        REG_QB: qb_r <= cfg_wdata;
        REG_MN: mn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = rdy && !ovalid_r;
  assign go = in_tvalid && in_tready;
  // hold the item: datapath reads it across the whole run
  always_ff @(posedge clk) begin
    if (go) begin
      roll_r <= in_tdata[24:0]; pitch_r <= in_tdata[48:25];
      rr_r <= in_tdata[76:49]; pr_r <= in_tdata[104:77];
    end
  end

  kabf_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_go(go), .in_rdy(rdy),
                    .cmd(cmd), .sts(sts), .done(done));
  // first item loads straight from the bus
  kabf_dp u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .dt(dt_r),
                .qa(qa_r), .qb(qb_r), .mn(mn_r),
                .roll_in(cmd.load ? $signed(in_tdata[24:0]) : roll_r),
                .pitch_in(cmd.load ? $signed(in_tdata[48:25]) : pitch_r),
                .rrate_in(rr_r), .prate_in(pr_r), .roll_o(ro), .pitch_o(po));

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (done) ovalid_r <= 1'b1;
    else if (out_tready && !done_d_r) ovalid_r <= 1'b0;
  end
  // capture from the delayed done flag so the last update is in the registers
  always_ff @(posedge clk) begin
    if (!rst_n) done_d_r <= 1'b0;
    else done_d_r <= done;
    if (done_d_r) odata_r <= {po, ro};
  end
  assign out_tvalid = ovalid_r && !done_d_r;
  assign out_tdata = odata_r;
endmodule
`default_nettype wire

### hdl/kabf_checker.sv
// Port-level checker for the tilt filter, bound to the top level.
`default_nettype none
module kabf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_norecv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accepted item with result pending");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tvalid, in_tready, out_tvalid}))
    else $error("handshake signal unknown");
endmodule
bind kalman_angle_bias_filter_top kabf_checker u_chk (.clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata));
`default_nettype wire

### sim/kalman_angle_bias_filter_top_tb.sv
// Self-checking testbench for the two-axis tilt Kalman filter top level.
`timescale 1ns / 1ps
`default_nettype none

class tilt_scoreboard;
  logic [23:0] dt;
  logic [30:0] qa, qb, mn;
  bit seeded;
  longint ang[2], bias[2], paa[2], pab[2], pba[2], pbb[2];
  logic [63:0] est_q[$];
  int errors;

  function void clear();
    dt = kabf_pkg::DT_RESET;
    qa = kabf_pkg::QA_RESET;
    qb = kabf_pkg::QB_RESET;
    mn = kabf_pkg::MN_RESET;
    seeded = 0;
    errors = 0;
    for (int a = 0; a < 2; a++) begin
      ang[a] = 0; bias[a] = 0; paa[a] = 0; pab[a] = 0; pba[a] = 0; pbb[a] = 0;
    end
  endfunction

  function void set_reg(logic [1:0] idx, logic [30:0] v);
    case (idx)
      kabf_pkg::REG_DT: dt = v[23:0];
      kabf_pkg::REG_QA: qa = v;
      kabf_pkg::REG_QB: qb = v;
      kabf_pkg::REG_MN: mn = v;
      default: ;
    endcase
  endfunction

  function longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // shift by 24 with rounding half away from zero; products here stay within 64 bits
  function longint shr24(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 64'sd8388608) >>> 24;
    return (v < 0) ? -m : m;
  endfunction

  function longint kgain(longint num, longint s);
    if (s <= 0) return 0;
    return clip((num * 64'sd16777216) / s);
  endfunction

  function longint filter_axis(int a, longint meas, longint rate);
    longint d, p00, p01, p10, p11, dtp11, inner, s, y, k0, k1;
    d = longint'(dt);
    p00 = paa[a]; p01 = pab[a]; p10 = pba[a]; p11 = pbb[a];
    ang[a] = clip(ang[a] + shr24(d * (rate - bias[a])));
    dtp11 = shr24(d * p11);
    inner = dtp11 - p01 - p10 + longint'(qa);
    p00 = clip(p00 + shr24(d * inner));
    p01 = clip(p01 - dtp11);
    p10 = clip(p10 - dtp11);
    p11 = clip(p11 + shr24(longint'(qb) * d));
    s = p00 + longint'(mn);
    k0 = kgain(p00, s);
    k1 = kgain(p10, s);
    y = clip(meas - ang[a]);
    ang[a] = clip(ang[a] + shr24(k0 * y));
    bias[a] = clip(bias[a] + shr24(k1 * y));
    paa[a] = clip(p00 - shr24(k0 * p00));
    pab[a] = clip(p01 - shr24(k0 * p01));
    pba[a] = clip(p10 - shr24(k1 * p00));
    pbb[a] = clip(p11 - shr24(k1 * p01));
    return ang[a];
  endfunction

  function void note_sample(logic [111:0] d);
    longint roll, pitch, rr, pr, r, p;
    roll = longint'($signed(d[24:0]));
    pitch = longint'($signed(d[48:25]));
    rr = longint'($signed(d[76:49]));
    pr = longint'($signed(d[104:77]));
    if (roll > 64'sd5898240 || roll < -64'sd5898240) pr = -pr;
    if (!seeded) begin
      for (int a = 0; a < 2; a++) begin
        bias[a] = 0; paa[a] = 0; pab[a] = 0; pba[a] = 0; pbb[a] = 0;
      end
      ang[0] = roll;
      ang[1] = pitch;
      seeded = 1;
      return;
    end
    r = filter_axis(0, roll, rr);
    p = filter_axis(1, pitch, pr);
    est_q.push_back({p[31:0], r[31:0]});
  endfunction

  task report_err(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_estimate(logic [63:0] got);
    logic [63:0] want;
    if (est_q.size() == 0) begin
      report_err($sformatf("unexpected result %h", got));
      return;
    end
    want = est_q.pop_front();
    if (got[31:0] !== want[31:0])
      report_err($sformatf("roll_est got %h want %h", got[31:0], want[31:0]));
    if (got[63:32] !== want[63:32])
      report_err($sformatf("pitch_est got %h want %h", got[63:32], want[63:32]));
  endtask
endclass

module kalman_angle_bias_filter_top_tb;
  import kabf_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 600;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_DT;
  logic [30:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [63:0] out_tdata;

  int send_idle_pct = 10;
  int recv_idle_pct = 72;
  longint cycles = 0;
  tilt_scoreboard sb;

  kalman_angle_bias_filter_top i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("[kalman_angle_bias_filter_top] ERROR");
      $finish;
    end
  end

  // receiver: check on accept, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_estimate(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays high after an accept until the next item or an idle cycle
  task automatic send_sample(logic [24:0] roll, logic [23:0] pitch,
                             logic [27:0] rr, logic [27:0] pr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {7'd0, pr, rr, pitch, roll};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample({7'd0, pr, rr, pitch, roll});
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.est_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_burst(int n);
    logic [24:0] r;
    logic [23:0] p;
    logic [27:0] a, b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        r = 25'($urandom); p = 24'($urandom); a = 28'($urandom); b = 28'($urandom);
      end else begin
        r = 25'($signed($urandom_range(23592960)) - 11796480);
        p = 24'($signed($urandom_range(11796480)) - 5898240);
        a = 28'($signed($urandom_range(262144000)) - 131072000);
        b = 28'($signed($urandom_range(262144000)) - 131072000);
      end
      send_sample(r, p, a, b);
    end
  endtask

  task automatic write_reg_rand_phase();
    drain();
    write_reg(REG_DT, 31'($urandom_range(16777215, 1)));
    write_reg(REG_QA, 31'($urandom_range(200000)));
    write_reg(REG_QB, 31'($urandom_range(200000)));
    write_reg(REG_MN, 31'($urandom_range(5000000, 1)));
    random_burst(270);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: seed item, extremes, roll beyond ninety both ways
    send_sample(25'sd0, 24'sd0, 28'sd0, 28'sd0);
    send_sample(25'sd11796480, 24'sd5898240, 28'sd131072000, 28'sd131072000);
    send_sample(-25'sd11796480, -24'sd5898240, -28'sd131072000, -28'sd131072000);
    send_sample(25'sd5898240, 24'sd0, 28'sd1000, 28'sd65536);
    send_sample(25'sd5898241, 24'sd100, 28'sd1000, 28'sd65536);
    send_sample(-25'sd5898241, -24'sd100, -28'sd1000, 28'sd65536);
    send_sample(25'h1FFFFFF, 24'hFFFFFF, 28'hFFFFFFF, 28'hFFFFFFF);
    send_sample(25'h0FFFFFF, 24'h7FFFFF, 28'h7FFFFFF, 28'h8000000);
    send_sample(25'h1000000, 24'h800000, 28'h8000000, 28'h7FFFFFF);
    // hold off until everything is out
    drain();

    // zero period, zero measurement noise and zero qa and qb
    write_reg(REG_DT, 31'd0);
    write_reg(REG_MN, 31'd0);
    write_reg(REG_QA, 31'd0);
    write_reg(REG_QB, 31'd0);
    random_burst(6);
    drain();

    // largest settings
    write_reg(REG_DT, 31'hFFFFFF);
    write_reg(REG_QA, 31'h7FFFFFFF);
    write_reg(REG_QB, 31'h7FFFFFFF);
    write_reg(REG_MN, 31'h7FFFFFFF);
    random_burst(8);
    drain();

    write_reg(REG_DT, 31'd1);
    write_reg(REG_MN, 31'd1);
    random_burst(6);
    drain();

    // nominal settings, then random ones; three idling phases
    write_reg(REG_DT, 31'(DT_RESET));
    write_reg(REG_QA, 31'(QA_RESET));
    write_reg(REG_QB, 31'(QB_RESET));
    write_reg(REG_MN, 31'(MN_RESET));
    random_burst(270);
    send_idle_pct = 72;
    recv_idle_pct = 10;
    write_reg_rand_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(280);
    drain();

    if (sb.errors == 0 && sb.est_q.size() == 0) begin
      $display("[kalman_angle_bias_filter_top] OK");
    end else begin
      $display("[kalman_angle_bias_filter_top] ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
